@@ hw/rtl/tuner_seek_controller_unit_defines.svh @@
// Assertion macros shared by the tuner seek controller RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef TUNER_SEEK_CONTROLLER_UNIT_DEFINES_SVH
`define TUNER_SEEK_CONTROLLER_UNIT_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define TSC_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tuner seek controller invariant violated");

// When the antecedent holds, the consequent holds in the same cycle.
`define TSC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tuner seek controller implication violated");

// When the antecedent holds, the consequent holds in the next cycle.
`define TSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tuner seek controller sequence violated");

`endif

@@ hw/rtl/tsc_pkg.sv @@
package tsc_pkg;

	// Band limits and step sizes.
	localparam logic [13:0] FM_MAX   = 14'd10800;
	localparam logic [13:0] FM_MIN   = 14'd8750;
	localparam logic [13:0] FM_STEP  = 14'd10;
	localparam logic [13:0] FM_RESET = 14'd9600;
	localparam logic [21:0] AM_MAX   = 22'd3000000;
	localparam logic [21:0] AM_MIN   = 22'd15000;
	localparam logic [21:0] AM_RESET = 22'd700000;

	// Step index range and reset value.
	localparam logic [2:0] STEP_IDX_MAX   = 3'd5;
	localparam logic [2:0] STEP_IDX_RESET = 3'd2;

	// Configuration reset values.
	localparam logic [6:0] FM_THR_RESET = 7'd12;
	localparam logic [6:0] AM_THR_RESET = 7'd8;
	localparam logic [7:0] DWELL_RESET  = 8'd8;

	// Division by 100 through a reciprocal: exact for any dividend below 2^30.
	localparam int unsigned DIV100_SHIFT = 32;
	localparam logic [25:0] DIV100_MUL   = 26'd42949673;
	localparam logic [6:0]  DIVISOR_100  = 7'd100;
	localparam logic [3:0]  BFO_SCALE    = 4'd10;

	// Event codes.
	localparam logic [3:0] EV_TICK       = 4'd0;
	localparam logic [3:0] EV_STEP_UP    = 4'd1;
	localparam logic [3:0] EV_STEP_DOWN  = 4'd2;
	localparam logic [3:0] EV_SCAN_UP    = 4'd3;
	localparam logic [3:0] EV_SCAN_DOWN  = 4'd4;
	localparam logic [3:0] EV_STOP       = 4'd5;
	localparam logic [3:0] EV_INDEX_UP   = 4'd6;
	localparam logic [3:0] EV_INDEX_DOWN = 4'd7;
	localparam logic [3:0] EV_DIRECT     = 4'd8;

	// Band codes.
	localparam logic [1:0] BAND_FM  = 2'd0;
	localparam logic [1:0] BAND_AM  = 2'd1;
	localparam logic [1:0] BAND_LSB = 2'd2;
	localparam logic [1:0] BAND_USB = 2'd3;

	// Configuration register indexes.
	localparam logic [3:0] REG_BAND_MODE = 4'd0;
	localparam logic [3:0] REG_FM_THR    = 4'd1;
	localparam logic [3:0] REG_AM_THR    = 4'd2;
	localparam logic [3:0] REG_DWELL     = 4'd3;

	// Scan direction.
	typedef enum logic [1:0] {
		SCAN_OFF  = 2'd0,
		SCAN_UP   = 2'd1,
		SCAN_DOWN = 2'd2
	} scan_dir_t;

	// AM step in 10 Hz units for a step index.
	function automatic logic [16:0] am_step_units(input logic [2:0] idx);
		logic [16:0] units;
		unique case (idx)
			3'd0:    units = 17'd1;
			3'd1:    units = 17'd10;
			3'd2:    units = 17'd100;
			3'd3:    units = 17'd1000;
			3'd4:    units = 17'd10000;
			default: units = 17'd100000;
		endcase
		return units;
	endfunction

endpackage

@@ hw/rtl/tuner_seek_controller_unit.sv @@
// Channel  | Handshake            | Word
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_stall  | mode, snr_db, entered_frequency
// output   | out_valid / out_stall| fm_frequency .. entry_rejected (one word)
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One input word yields one output word, registered in stage one then in stage two;
// a new word can be accepted every cycle while in_stall is low. Stage one updates
// the tuning state; stage two divides the AM frequency by 100 with a reciprocal
// multiplier and makes the retune decision. Reset is asynchronous and restores
// configuration, tuning state and valid bits, not stage words. A stalled output
// holds its word; stage one still accepts one more input word before in_stall rises.
`include "tuner_seek_controller_unit_defines.svh"

module tuner_seek_controller_unit
	import tsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  mode,
	input  logic [6:0]  snr_db,
	input  logic [23:0] entered_frequency,
	// Output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [13:0] fm_frequency,
	output logic [21:0] am_frequency,
	output logic [14:0] am_khz,
	output logic [9:0]  bfo_offset_hz,
	output logic        pll_retune,
	output logic [1:0]  scan_state,
	output logic [2:0]  step_index,
	output logic        station_found,
	output logic        entry_rejected
);

	// Configuration registers
	logic [1:0] band_mode_q;
	logic [6:0] fm_thr_q;
	logic [6:0] am_thr_q;
	logic [7:0] dwell_ticks_q;

	// Tuning state
	logic [13:0] fm_freq_q;
	logic [21:0] am_freq_q;
	logic [2:0]  step_sel_q;
	scan_dir_t   scan_q;
	logic [7:0]  dwell_q;
	logic [14:0] sent_khz_q;
	logic        first_tune_q;

	// Pipeline control
	logic s1_valid_q;
	logic out_valid_q;
	logic s2_load;
	logic in_accept;

	// Stage one word
	logic [13:0] fm_s1;
	logic [21:0] am_s1;
	scan_dir_t   scan_s1;
	logic [2:0]  step_s1;
	logic        found_s1;
	logic        rejected_s1;
	logic        tuned_s1;
	logic        ssb_s1;

	// Stage two word
	logic [13:0] fm_s2;
	logic [21:0] am_s2;
	logic [14:0] khz_s2;
	logic [9:0]  bfo_s2;
	logic        retune_s2;
	logic [1:0]  scan_s2;
	logic [2:0]  step_s2;
	logic        found_s2;
	logic        rejected_s2;

	// Next-state logic
	logic [13:0] fm_nxt;
	logic [21:0] am_nxt;
	logic [2:0]  step_nxt;
	scan_dir_t   scan_nxt;
	logic [7:0]  dwell_nxt;
	logic        found_nxt;
	logic        rejected_nxt;
	logic        tuned_nxt;
	logic        do_move;
	logic        move_up;
	logic [7:0]  dwell_dec;
	logic [6:0]  thr_sel;
	logic [16:0] step_units;
	logic [22:0] am_up_sum;
	logic [22:0] am_dn_floor;
	logic [14:0] fm_up_sum;

	// Stage two arithmetic
	logic [47:0] div_prod;
	logic [14:0] khz_calc;
	logic [21:0] khz_times_100;
	logic [21:0] rem_full;
	logic [6:0]  rem_calc;
	logic [9:0]  bfo_calc;
	logic        retune_calc;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign s2_load   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall  = s1_valid_q && !s2_load;
	assign in_accept = in_valid && !in_stall;

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_mode_q   <= BAND_FM;
			fm_thr_q      <= FM_THR_RESET;
			am_thr_q      <= AM_THR_RESET;
			dwell_ticks_q <= DWELL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BAND_MODE: band_mode_q   <= cfg_data[1:0];
				REG_FM_THR:    fm_thr_q      <= cfg_data[6:0];
				REG_AM_THR:    am_thr_q      <= cfg_data[6:0];
				REG_DWELL:     dwell_ticks_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Step arithmetic shared by keys and scan moves.
	assign step_units  = am_step_units(step_sel_q);
	assign am_up_sum   = {1'b0, am_freq_q} + {6'd0, step_units};
	assign am_dn_floor = {1'b0, AM_MIN} + {6'd0, step_units};
	assign fm_up_sum   = {1'b0, fm_freq_q} + {1'b0, FM_STEP};
	assign dwell_dec   = dwell_q - 8'd1;
	assign thr_sel     = (band_mode_q == BAND_FM) ? fm_thr_q : am_thr_q;

	// Event decode and next tuning state.
	always_comb begin
		fm_nxt       = fm_freq_q;
		am_nxt       = am_freq_q;
		step_nxt     = step_sel_q;
		scan_nxt     = scan_q;
		dwell_nxt    = dwell_q;
		found_nxt    = 1'b0;
		rejected_nxt = 1'b0;
		tuned_nxt    = 1'b0;
		do_move      = 1'b0;
		move_up      = 1'b0;

		unique case (mode)
			EV_TICK: begin
				if (scan_q != SCAN_OFF) begin
					if (dwell_q != 8'd0) begin
						dwell_nxt = dwell_dec;
						if (dwell_dec == 8'd0) begin
							if (snr_db >= thr_sel) begin
								scan_nxt  = SCAN_OFF;
								found_nxt = 1'b1;
							end else begin
								do_move   = 1'b1;
								dwell_nxt = dwell_ticks_q;
							end
						end
					end else begin
						do_move   = 1'b1;
						dwell_nxt = dwell_ticks_q;
					end
					move_up = (scan_q == SCAN_UP);
				end
			end
			EV_STEP_UP, EV_STEP_DOWN: begin
				if (scan_q != SCAN_OFF) begin
					scan_nxt = SCAN_OFF;
				end else begin
					do_move = 1'b1;
					move_up = (mode == EV_STEP_UP);
				end
			end
			EV_SCAN_UP, EV_SCAN_DOWN: begin
				if (scan_q == SCAN_OFF) begin
					scan_nxt  = (mode == EV_SCAN_UP) ? SCAN_UP : SCAN_DOWN;
					dwell_nxt = 8'd0;
				end else begin
					scan_nxt = SCAN_OFF;
				end
			end
			EV_STOP: begin
				scan_nxt = SCAN_OFF;
			end
			EV_INDEX_UP: begin
				if (band_mode_q != BAND_FM) begin
					step_nxt = (step_sel_q >= STEP_IDX_MAX) ? 3'd0 : step_sel_q + 3'd1;
				end
			end
			EV_INDEX_DOWN: begin
				if (band_mode_q != BAND_FM) begin
					step_nxt = (step_sel_q == 3'd0 || step_sel_q > STEP_IDX_MAX) ?
						STEP_IDX_MAX : step_sel_q - 3'd1;
				end
			end
			EV_DIRECT: begin
				if (band_mode_q == BAND_FM) begin
					if (entered_frequency >= {10'd0, FM_MIN} &&
					    entered_frequency <= {10'd0, FM_MAX}) begin
						fm_nxt = entered_frequency[13:0];
					end else begin
						rejected_nxt = 1'b1;
					end
				end else begin
					if (entered_frequency >= {2'd0, AM_MIN} &&
					    entered_frequency <= {2'd0, AM_MAX}) begin
						am_nxt    = entered_frequency[21:0];
						tuned_nxt = 1'b1;
					end else begin
						rejected_nxt = 1'b1;
					end
				end
			end
			default: ;
		endcase

		// One step of the active band, wrapping at the band edges.
		if (do_move) begin
			if (band_mode_q == BAND_FM) begin
				if (move_up) begin
					fm_nxt = (fm_up_sum <= {1'b0, FM_MAX}) ? fm_up_sum[13:0] : FM_MIN;
				end else begin
					fm_nxt = (fm_freq_q >= FM_MIN + FM_STEP) ? fm_freq_q - FM_STEP : FM_MAX;
				end
			end else begin
				if (move_up) begin
					am_nxt = (am_up_sum <= {1'b0, AM_MAX}) ? am_up_sum[21:0] : AM_MIN;
				end else begin
					am_nxt = ({1'b0, am_freq_q} >= am_dn_floor) ?
						am_freq_q - {5'd0, step_units} : AM_MAX;
				end
				tuned_nxt = 1'b1;
			end
		end
	end

	// Tuning state and stage one valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fm_freq_q  <= FM_RESET;
			am_freq_q  <= AM_RESET;
			step_sel_q <= STEP_IDX_RESET;
			scan_q     <= SCAN_OFF;
			dwell_q    <= 8'd0;
			s1_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				fm_freq_q  <= fm_nxt;
				am_freq_q  <= am_nxt;
				step_sel_q <= step_nxt;
				scan_q     <= scan_nxt;
				dwell_q    <= dwell_nxt;
				s1_valid_q <= 1'b1;
			end else if (s2_load) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// Stage one word.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			fm_s1       <= fm_nxt;
			am_s1       <= am_nxt;
			scan_s1     <= scan_nxt;
			step_s1     <= step_nxt;
			found_s1    <= found_nxt;
			rejected_s1 <= rejected_nxt;
			tuned_s1    <= tuned_nxt;
			ssb_s1      <= (band_mode_q == BAND_LSB) || (band_mode_q == BAND_USB);
		end
	end

	// Divide by 100 through the reciprocal, then the remainder for the BFO.
	assign div_prod      = 48'(am_s1) * 48'(DIV100_MUL);
	assign khz_calc      = div_prod[DIV100_SHIFT +: 15];
	assign khz_times_100 = 22'(khz_calc) * 22'(DIVISOR_100);
	assign rem_full      = am_s1 - khz_times_100;
	assign rem_calc      = rem_full[6:0];
	assign bfo_calc      = ssb_s1 ? 10'(rem_calc) * 10'(BFO_SCALE) : 10'd0;
	assign retune_calc   = tuned_s1 && (first_tune_q || (khz_calc != sent_khz_q));

	// Last kHz value sent to the PLL, and stage two valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_khz_q   <= 15'd0;
			first_tune_q <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			if (s2_load) begin
				out_valid_q <= 1'b1;
				if (retune_calc) begin
					sent_khz_q   <= khz_calc;
					first_tune_q <= 1'b0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage two word.
	always_ff @(posedge clk) begin
		if (s2_load) begin
			fm_s2       <= fm_s1;
			am_s2       <= am_s1;
			khz_s2      <= khz_calc;
			bfo_s2      <= bfo_calc;
			retune_s2   <= retune_calc;
			scan_s2     <= scan_s1;
			step_s2     <= step_s1;
			found_s2    <= found_s1;
			rejected_s2 <= rejected_s1;
		end
	end

	// Output word.
	assign out_valid      = out_valid_q;
	assign fm_frequency   = fm_s2;
	assign am_frequency   = am_s2;
	assign am_khz         = khz_s2;
	assign bfo_offset_hz  = bfo_s2;
	assign pll_retune     = retune_s2;
	assign scan_state     = scan_s2;
	assign step_index     = step_s2;
	assign station_found  = found_s2;
	assign entry_rejected = rejected_s2;

	// Checks on the tuning state and the retune bookkeeping.
	`TSC_ASSERT_ALWAYS(a_fm_in_band, fm_freq_q >= FM_MIN && fm_freq_q <= FM_MAX)
	`TSC_ASSERT_ALWAYS(a_am_in_band, am_freq_q >= AM_MIN && am_freq_q <= AM_MAX)
	`TSC_ASSERT_ALWAYS(a_step_in_range, step_sel_q <= STEP_IDX_MAX)
	`TSC_ASSERT_SAME(a_found_stops_scan, out_valid_q && found_s2, scan_s2 == SCAN_OFF)
	`TSC_ASSERT_NEXT(a_retune_records, s2_load && retune_calc,
		!first_tune_q && sent_khz_q == $past(khz_calc))

endmodule
